>>> rtl/core/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// shared sizes, codes and types of the replace-min sorted store
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int DEPTH     = 64;
    localparam int VAL_W     = 30;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int SUM_W     = 37;
    localparam int OUT_SUM_W = 36;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = $clog2(DEPTH);

    // operation codes, code 3 is unused and leaves the store alone
    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_REPLACE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             rep;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } t_cell_ctl;

endpackage

>>> rtl/core/rms_if.sv
// ----------------------------------------------------------------------------
// rms_in_if / rms_out_if
// valid/ready channels carrying operation items and result items
// ----------------------------------------------------------------------------
interface rms_in_if;
    logic                         valid;
    logic                         ready;
    logic [rms_pkg::OP_W-1:0]     op;
    logic [rms_pkg::VAL_W-1:0]    value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface rms_out_if;
    logic                          valid;
    logic                          ready;
    logic [rms_pkg::OUT_SUM_W-1:0] total_sum;
    logic [rms_pkg::ST_W-1:0]      status;

    modport source (output valid, output total_sum, output status, input ready);
    modport sink   (input valid, input total_sum, input status, output ready);
endinterface

>>> rtl/core/replace_min_sorted_store.sv
// ----------------------------------------------------------------------------
// replace_min_sorted_store
// ascending store of up to DEPTH values with count and running sum
// ----------------------------------------------------------------------------
// usage
//   i_item carries one operation per item: insert a value, replace the
//   minimum with a value, or clear the store. o_result returns one item per
//   operation: the sum of the held values afterwards and a status (done,
//   insert ignored on a full store, replace ignored on an empty store).
//   the result is registered in the output register (or the skid register).
//   one item per cycle while the skid is empty; the whole update is done in a
//   single pass through the chain of compare-and-shift cells, one per slot,
//   and a 37-bit add/subtract for the sum.
//   when the receiver stalls, one further result is held in a skid register
//   and i_item.ready drops until the skid drains.
//   reset (synchronous, active low) empties the store and both output
//   registers; slot contents are not cleared, only the count is, and slots
//   at or above the count are never read. no clearing pass is needed.
// ----------------------------------------------------------------------------
module replace_min_sorted_store (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rms_in_if.sink     i_item,
    rms_out_if.source  o_result
);

    localparam int DEPTH = rms_pkg::DEPTH;

    // chain wiring, one entry per cell
    logic [rms_pkg::VAL_W-1:0] cell_val [DEPTH];
    logic                      cell_gt  [DEPTH];
    logic                      cell_lt  [DEPTH];

    rms_pkg::t_cell_ctl        ctl;

    // store bookkeeping
    logic [rms_pkg::CNT_W-1:0] r_count;
    logic [rms_pkg::CNT_W-1:0] n_count;
    logic [rms_pkg::SUM_W-1:0] r_sum;
    logic [rms_pkg::SUM_W-1:0] n_sum;
    rms_pkg::t_status          res_status;

    // output register plus skid register
    logic                          r_out_vld;
    logic                          n_out_vld;
    logic [rms_pkg::OUT_SUM_W-1:0] r_out_sum;
    logic [rms_pkg::OUT_SUM_W-1:0] n_out_sum;
    rms_pkg::t_status              r_out_status;
    rms_pkg::t_status              n_out_status;
    logic                          r_skid_vld;
    logic                          n_skid_vld;
    logic [rms_pkg::OUT_SUM_W-1:0] r_skid_sum;
    logic [rms_pkg::OUT_SUM_W-1:0] n_skid_sum;
    rms_pkg::t_status              r_skid_status;
    rms_pkg::t_status              n_skid_status;

    logic item_fire;
    logic out_fire;
    logic full;
    logic empty;

    assign i_item.ready = !r_skid_vld;
    assign item_fire    = i_item.valid && i_item.ready;
    assign out_fire     = r_out_vld && o_result.ready;
    assign full         = r_count == rms_pkg::CNT_W'(DEPTH);
    assign empty        = r_count == '0;

    // broadcast to the chain, only operations that really change the slots
    assign ctl.ins   = item_fire && (i_item.op == rms_pkg::OP_INSERT) && !full;
    assign ctl.rep   = item_fire && (i_item.op == rms_pkg::OP_REPLACE) && !empty;
    assign ctl.value = i_item.value;
    assign ctl.count = r_count;

    // ------------------------------------------------------------------
    // chain of cells, slot 0 holds the minimum
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [rms_pkg::VAL_W-1:0] left_val;
        logic                      left_gt;
        logic [rms_pkg::VAL_W-1:0] right_val;
        logic                      right_lt;

        if (g == 0) begin : g_head
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
            assign left_gt  = cell_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_val = '0;
            assign right_lt  = 1'b0;
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
            assign right_lt  = cell_lt[g+1];
        end

        rms_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_idx       (rms_pkg::IDX_W'(g)),
            .i_left_val  (left_val),
            .i_left_gt   (left_gt),
            .i_right_val (right_val),
            .i_right_lt  (right_lt),
            .o_val       (cell_val[g]),
            .o_gt        (cell_gt[g]),
            .o_lt        (cell_lt[g])
        );
    end

    // ------------------------------------------------------------------
    // count, running sum and status of the item being taken
    // ------------------------------------------------------------------
    always_comb begin
        n_count    = r_count;
        n_sum      = r_sum;
        res_status = rms_pkg::ST_DONE;
        if (item_fire) begin
            unique case (i_item.op)
                rms_pkg::OP_INSERT: begin
                    if (full) begin
                        res_status = rms_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + rms_pkg::CNT_W'(1);
                        n_sum   = r_sum + rms_pkg::SUM_W'(i_item.value);
                    end
                end
                rms_pkg::OP_REPLACE: begin
                    if (empty) begin
                        res_status = rms_pkg::ST_EMPTY;
                    end else begin
                        // old minimum leaves, new value comes in
                        n_sum = r_sum - rms_pkg::SUM_W'(cell_val[0])
                              + rms_pkg::SUM_W'(i_item.value);
                    end
                end
                rms_pkg::OP_CLEAR: begin
                    n_count = '0;
                    n_sum   = '0;
                end
                default: begin
                    // unused code, nothing changes
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // ------------------------------------------------------------------
    // result path: output register with one skid entry behind it
    // ------------------------------------------------------------------
    always_comb begin
        n_out_vld     = r_out_vld;
        n_out_sum     = r_out_sum;
        n_out_status  = r_out_status;
        n_skid_vld    = r_skid_vld;
        n_skid_sum    = r_skid_sum;
        n_skid_status = r_skid_status;

        if (out_fire) begin
            // skid entry moves forward, or the output register empties
            n_out_vld    = r_skid_vld;
            n_out_sum    = r_skid_sum;
            n_out_status = r_skid_status;
            n_skid_vld   = 1'b0;
        end

        if (item_fire) begin
            // skid is empty whenever an item is taken
            if (!r_out_vld || out_fire) begin
                n_out_vld    = 1'b1;
                n_out_sum    = n_sum[rms_pkg::OUT_SUM_W-1:0];
                n_out_status = res_status;
            end else begin
                n_skid_vld    = 1'b1;
                n_skid_sum    = n_sum[rms_pkg::OUT_SUM_W-1:0];
                n_skid_status = res_status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sum     <= n_out_sum;
        r_out_status  <= n_out_status;
        r_skid_sum    <= n_skid_sum;
        r_skid_status <= n_skid_status;
    end

    assign o_result.valid     = r_out_vld;
    assign o_result.total_sum = r_out_sum;
    assign o_result.status    = r_out_status;

`ifndef SYNTH
    // fill level stays within the chain
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rms_pkg::CNT_W'(DEPTH))
        else $error("count above depth");

    // skid only ever holds an item behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid valid with empty output register");

    // clear empties the store and the sum
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_fire && i_item.op == rms_pkg::OP_CLEAR) |=> (r_count == '0 && r_sum == '0))
        else $error("clear did not empty the store");

    // an ignored replace leaves count and sum alone
    a_replace_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_fire && i_item.op == rms_pkg::OP_REPLACE && empty)
        |=> ($stable(r_sum) && r_count == '0))
        else $error("replace on empty store changed state");

    // occupied slots stay in ascending order
    for (genvar k = 1; k < DEPTH; k++) begin : g_order_chk
        a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (rms_pkg::CNT_W'(k) < r_count) |-> (cell_val[k-1] <= cell_val[k]))
            else $error("store out of order");
    end
`endif

endmodule

>>> rtl/core/rms_cell.sv
// ----------------------------------------------------------------------------
// rms_cell
// one slot of the sorted chain: compare against the broadcast value and shift
// ----------------------------------------------------------------------------
module rms_cell (
    input  logic                         i_clk,
    input  rms_pkg::t_cell_ctl           i_ctl,
    input  logic [rms_pkg::IDX_W-1:0]    i_idx,
    input  logic [rms_pkg::VAL_W-1:0]    i_left_val,
    input  logic                         i_left_gt,
    input  logic [rms_pkg::VAL_W-1:0]    i_right_val,
    input  logic                         i_right_lt,
    output logic [rms_pkg::VAL_W-1:0]    o_val,
    output logic                         o_gt,
    output logic                         o_lt
);

    logic [rms_pkg::VAL_W-1:0] r_val;
    logic [rms_pkg::VAL_W-1:0] n_val;
    logic                      occupied;
    logic                      is_end;
    logic                      is_first;

    assign occupied = rms_pkg::CNT_W'(i_idx) < i_ctl.count;
    assign is_end   = rms_pkg::CNT_W'(i_idx) == i_ctl.count;
    assign is_first = i_idx == '0;

    // held value strictly above / below the incoming value
    assign o_gt  = occupied && (r_val > i_ctl.value);
    assign o_lt  = occupied && (r_val < i_ctl.value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        priority if (i_ctl.ins) begin
            // larger values move up one slot, new value lands at the gap
            priority if (i_left_gt) begin
                n_val = i_left_val;
            end else if (o_gt || is_end) begin
                n_val = i_ctl.value;
            end else begin
                n_val = r_val;
            end
        end else if (i_ctl.rep && occupied) begin
            // smaller values move down one slot over the old minimum
            priority if (i_right_lt) begin
                n_val = i_right_val;
            end else if (is_first || o_lt) begin
                n_val = i_ctl.value;
            end else begin
                n_val = r_val;
            end
        end else begin
            // slot keeps its value
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
